FILE: rtl/wtsp_pkg.sv
`default_nettype none
package wtsp_pkg;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_W = 64;
	localparam int unsigned IDX_W = 3;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned WIN_W = 16;
	localparam int unsigned NDC_LIMIT_BITS = 40;
	localparam int unsigned NDC_W = NDC_LIMIT_BITS + 2;
	localparam int unsigned CLIP_W = 68;
endpackage
`default_nettype wire

FILE: rtl/wtsp_if.sv
`default_nettype none
interface wtsp_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [15:0] window_width;
	logic [15:0] window_height;
	modport source (output valid, pos_x, pos_y, pos_z, window_width, window_height,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, window_width, window_height,
		output ready);
endinterface

interface wtsp_out_if;
	logic valid;
	logic ready;
	logic visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic saturated;
	modport source (output valid, visible, screen_x, screen_y, saturated, input ready);
	modport sink (input valid, visible, screen_x, screen_y, saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/wtsp_clip.sv
`default_nettype none
// clip rows x, y, w: products registered, then summed and floored
module wtsp_clip import wtsp_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [31:0] x,
	input  wire logic signed [31:0] y,
	input  wire logic signed [31:0] z,
	input  wire logic signed [31:0] m0,
	input  wire logic signed [31:0] m1,
	input  wire logic signed [31:0] m2,
	input  wire logic signed [31:0] m3,
	output logic signed [CLIP_W-1:0] clip
);
	logic signed [63:0] px_s1, py_s1, pz_s1;
	logic signed [31:0] m3_s1;
	logic signed [65:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= x * m0;
			py_s1 <= y * m1;
			pz_s1 <= z * m2;
			m3_s1 <= m3;
		end
	end

	// one exact sum then a single floor shift
	assign sum = 66'(px_s1) + 66'(py_s1) + 66'(pz_s1);
	always_ff @(posedge clk) begin
		if (en) clip <= CLIP_W'(sum >>> FRAC_BITS) + CLIP_W'(m3_s1);
	end
endmodule
`default_nettype wire

FILE: rtl/wtsp_div.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
// |q| = |c| * 2^F / w with the sign of c, |q| held at 2^40 when the integer part overflows
module wtsp_div import wtsp_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [CLIP_W-1:0] c,
	input  wire logic signed [CLIP_W-1:0] w,
	output logic signed [NDC_W-1:0] q
);
	localparam int unsigned IB = NDC_LIMIT_BITS - FRAC_BITS;
	localparam int unsigned NS = NDC_LIMIT_BITS;
	localparam int unsigned MW = CLIP_W + FRAC_BITS;
	localparam int unsigned DW = CLIP_W;

	logic [MW-1:0] rem_s [NS+1];
	logic [DW-1:0] den_s [NS+1];
	logic [NS-1:0] quo_s [NS+1];
	logic neg_s [NS+1];
	logic ovf_s [NS+1];
	logic [CLIP_W-1:0] mag;

	assign mag = c[CLIP_W-1] ? CLIP_W'(-c) : CLIP_W'(c);

	always_comb begin
		rem_s[0] = {mag, FRAC_BITS'(0)};
		den_s[0] = DW'(w);
		quo_s[0] = '0;
		neg_s[0] = c[CLIP_W-1];
		// integer part overflows when |c| >= w * 2^IB
		ovf_s[0] = (MW+IB)'(mag) >= ((MW+IB)'(w) << IB);
	end

	for (genvar i = 0; i < NS; i++) begin : g_st
		localparam int unsigned SH = NS - 1 - i;
		logic [MW+NS-1:0] trial;
		logic take;
		assign trial = (MW+NS)'(den_s[i]) << SH;
		assign take = (MW+NS)'(rem_s[i]) >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? MW'((MW+NS)'(rem_s[i]) - trial) : rem_s[i];
				quo_s[i+1] <= quo_s[i] | (take ? (NS'(1) << SH) : NS'(0));
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	logic [NDC_W-1:0] mq;
	assign mq = ovf_s[NS] ? (NDC_W'(1) << NDC_LIMIT_BITS) : NDC_W'(quo_s[NS]);
	assign q = neg_s[NS] ? NDC_W'(-mq) : mq;
endmodule
`default_nettype wire

FILE: rtl/world_to_screen_projection_core.sv
`default_nettype none
// world_to_screen_projection_core
// projects a world point through a column-major 4x4 matrix to screen space
// channels: in (pos_x/y/z, window_width/height) and out (visible, screen_x,
//   screen_y, saturated), valid/ready, a request moves when both are high
// cfg: cfg_we, cfg_idx, cfg_data write one 64-bit matrix pair per cycle; the user
//   must write only while no request is in flight, the block does not enforce it
// throughput: one request per cycle unless the output stalls, fully pipelined
// stages: 2 clip stages, 40 divider stages, 1 multiply stage, 1 saturate
//   stage, from accept to result valid
// the divider depth (one quotient bit per stage) sets the latency
// when out.valid is high and out.ready is low the whole pipeline holds;
//   in.ready drops with it, empty slots still move forward otherwise
// reset clears the matrix and all valid bits; no request is lost or repeated
module world_to_screen_projection_core import wtsp_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [IDX_W-1:0] cfg_idx,
	input  wire logic [REG_W-1:0] cfg_data,
	wtsp_in_if.sink in,
	wtsp_out_if.source out
);
	localparam int unsigned LAT = 2 + NDC_LIMIT_BITS + 2;
	localparam logic signed [CLIP_W-1:0] W_TH =
		CLIP_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

	logic [REG_W-1:0] mat_q [NUM_REGS];
	logic [LAT-1:0] vld_q;
	logic en;

	// global stall: advance only when the last stage can drain
	assign en = out.ready || !out.valid;
	assign in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) mat_q[i] <= '0;
		end else if (cfg_we) begin
			mat_q[cfg_idx] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in.valid};
	end

	function automatic logic signed [31:0] ent(input logic [REG_W-1:0] p, input bit hi);
		return hi ? p[63:32] : p[31:0];
	endfunction

	// clip rows x, y, w use matrix entries r, 4+r, 8+r, 12+r
	logic signed [CLIP_W-1:0] cx, cy, cw;
	wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_cx (.clk, .en, .x(in.pos_x), .y(in.pos_y),
		.z(in.pos_z), .m0(ent(mat_q[0], 1'b0)), .m1(ent(mat_q[2], 1'b0)),
		.m2(ent(mat_q[4], 1'b0)), .m3(ent(mat_q[6], 1'b0)), .clip(cx));
	wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_cy (.clk, .en, .x(in.pos_x), .y(in.pos_y),
		.z(in.pos_z), .m0(ent(mat_q[0], 1'b1)), .m1(ent(mat_q[2], 1'b1)),
		.m2(ent(mat_q[4], 1'b1)), .m3(ent(mat_q[6], 1'b1)), .clip(cy));
	wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_cw (.clk, .en, .x(in.pos_x), .y(in.pos_y),
		.z(in.pos_z), .m0(ent(mat_q[1], 1'b1)), .m1(ent(mat_q[3], 1'b1)),
		.m2(ent(mat_q[5], 1'b1)), .m3(ent(mat_q[7], 1'b1)), .clip(cw));

	// window halves travel alongside the clip stages
	logic [WIN_W-2:0] hw_s1, hh_s1, hw_s2, hh_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			hw_s1 <= in.window_width[WIN_W-1:1];
			hh_s1 <= in.window_height[WIN_W-1:1];
			hw_s2 <= hw_s1;
			hh_s2 <= hh_s1;
		end
	end

	// visibility, with a safe divisor when rejected
	logic vis;
	logic signed [CLIP_W-1:0] wdiv;
	assign vis = cw >= W_TH;
	assign wdiv = vis ? cw : W_TH;

	logic signed [NDC_W-1:0] nx, ny;
	wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk, .en, .c(cx), .w(wdiv), .q(nx));
	wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk, .en, .c(cy), .w(wdiv), .q(ny));

	// side pipe for visibility and halves over the divider depth
	logic vis_d [NDC_LIMIT_BITS+1];
	logic [WIN_W-2:0] hw_d [NDC_LIMIT_BITS+1];
	logic [WIN_W-2:0] hh_d [NDC_LIMIT_BITS+1];
	assign vis_d[0] = vis;
	assign hw_d[0] = hw_s2;
	assign hh_d[0] = hh_s2;
	for (genvar i = 0; i < NDC_LIMIT_BITS; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				vis_d[i+1] <= vis_d[i];
				hw_d[i+1] <= hw_d[i];
				hh_d[i+1] <= hh_d[i];
			end
		end
	end

	// screen = ndc * k + half * 2^F, with k = hw+1 and 1-hh
	localparam int unsigned PW = NDC_W + WIN_W + 1;
	localparam int unsigned SW = PW + 2;
	logic signed [PW-1:0] px_s3, py_s3;
	logic [WIN_W-2:0] hw_s3, hh_s3;
	logic vis_s3;
	logic signed [WIN_W:0] kx, ky;
	assign kx = (WIN_W+1)'(hw_d[NDC_LIMIT_BITS]) + (WIN_W+1)'(1);
	assign ky = (WIN_W+1)'(1) - (WIN_W+1)'(hh_d[NDC_LIMIT_BITS]);
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= PW'(nx) * PW'(kx);
			py_s3 <= PW'(ny) * PW'(ky);
			hw_s3 <= hw_d[NDC_LIMIT_BITS];
			hh_s3 <= hh_d[NDC_LIMIT_BITS];
			vis_s3 <= vis_d[NDC_LIMIT_BITS];
		end
	end

	logic signed [SW-1:0] sx, sy;
	assign sx = SW'(px_s3) + (SW'({1'b0, hw_s3}) <<< FRAC_BITS);
	assign sy = SW'(py_s3) + (SW'({1'b0, hh_s3}) <<< FRAC_BITS);

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [SW-1:0] v);
		if (v > SW'(32'sh7fffffff)) return 32'sh7fffffff;
		if (v < -SW'(33'sh080000000)) return 32'sh80000000;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic ovr(input logic signed [SW-1:0] v);
		return (v > SW'(32'sh7fffffff)) || (v < -SW'(33'sh080000000));
	endfunction

	// output register
	logic vis_s4, sat_s4;
	logic signed [COORD_W-1:0] sx_s4, sy_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			vis_s4 <= vis_s3;
			sx_s4 <= vis_s3 ? sat(sx) : '0;
			sy_s4 <= vis_s3 ? sat(sy) : '0;
			sat_s4 <= vis_s3 && (ovr(sx) || ovr(sy));
		end
	end

	assign out.valid = vld_q[LAT-1];
	assign out.visible = vis_s4;
	assign out.screen_x = sx_s4;
	assign out.screen_y = sy_s4;
	assign out.saturated = sat_s4;
endmodule
`default_nettype wire

FILE: verif/world_to_screen_projection_core_test.sv
`default_nettype none
module world_to_screen_projection_core_test;
	import wtsp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// clip w below this is rejected, round(0.1 * 2^16)
	localparam logic signed [67:0] W_MIN = 68'sd6554;
	localparam int RAND_PER_PHASE = 190;
	localparam int SETTLE_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0] window_width;
		logic [15:0] window_height;
	} point_t;

	typedef struct {
		logic visible;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic saturated;
	} screen_t;

	// one directed row: which matrix, the point, and an optional hand-typed answer
	typedef struct {
		int mtx_sel;
		point_t pt;
		bit typed;
		screen_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [REG_W-1:0] cfg_data;

	wtsp_in_if in_ch ();
	wtsp_out_if out_ch ();

	world_to_screen_projection_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in(in_ch),
		.out(out_ch)
	);

	// predictor copy of the matrix registers
	logic [REG_W-1:0] mtx_pairs [NUM_REGS];
	screen_t pending_screens [$];
	row_t directed_rows [$];

	int errors = 0;
	int results_seen = 0;
	int visible_seen = 0;
	int saturated_seen = 0;
	int idle_cycles = 0;
	bit calm = 0;
	int stall_left = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------- predictor ----------------

	function automatic logic signed [67:0] mtx_entry(int e);
		logic [63:0] p;
		logic signed [31:0] v;
		begin
			p = mtx_pairs[e / 2];
			v = (e % 2) ? p[63:32] : p[31:0];
			return v;
		end
	endfunction

	// one row of the clip vector, exact sum floored once
	function automatic logic signed [67:0] clip_row(int r, point_t p);
		logic signed [67:0] xs, ys, zs, acc;
		begin
			xs = p.pos_x;
			ys = p.pos_y;
			zs = p.pos_z;
			acc = xs * mtx_entry(r) + ys * mtx_entry(4 + r) + zs * mtx_entry(8 + r);
			return (acc >>> FRAC_BITS_DEF) + mtx_entry(12 + r);
		end
	endfunction

	// (c << frac) / w toward zero, magnitude held at 2^40
	function automatic logic signed [95:0] ndc_quot(logic signed [67:0] c,
			logic signed [67:0] w);
		logic [95:0] mag, d, q;
		begin
			mag = (c < 0) ? 96'(-c) : 96'(c);
			d = 96'(w);
			if (mag / d >= (96'd1 << (NDC_LIMIT_BITS - FRAC_BITS_DEF)))
				q = 96'd1 << NDC_LIMIT_BITS;
			else
				q = (mag << FRAC_BITS_DEF) / d;
			return (c < 0) ? -$signed(q) : $signed(q);
		end
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [95:0] v, ref logic flag);
		begin
			if (v > 96'sh7FFFFFFF) begin
				flag = 1'b1;
				return 32'sh7FFFFFFF;
			end
			if (v < -96'sh80000000) begin
				flag = 1'b1;
				return 32'sh80000000;
			end
			return v[31:0];
		end
	endfunction

	function automatic screen_t project_point(point_t p);
		logic signed [67:0] cx, cy, cw;
		logic signed [95:0] nx, ny, hw, hh;
		logic sat;
		screen_t s;
		begin
			cx = clip_row(0, p);
			cy = clip_row(1, p);
			cw = clip_row(3, p);
			sat = 1'b0;
			s.visible = (cw >= W_MIN);
			s.screen_x = '0;
			s.screen_y = '0;
			if (s.visible) begin
				hw = 96'(p.window_width >> 1);
				hh = 96'(p.window_height >> 1);
				nx = ndc_quot(cx, cw);
				ny = ndc_quot(cy, cw);
				s.screen_x = clamp32(nx * (hw + 1) + (hw <<< FRAC_BITS_DEF), sat);
				s.screen_y = clamp32(ny * (1 - hh) + (hh <<< FRAC_BITS_DEF), sat);
			end
			s.saturated = sat;
			return s;
		end
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic signed [31:0] rand_coord(int spread);
		begin
			if ($urandom_range(0, 9) == 0)
				return $urandom;
			return $signed($urandom_range(0, 2 * spread)) - spread;
		end
	endfunction

	function automatic point_t rand_point(bit lean_back);
		point_t p;
		begin
			p.pos_x = rand_coord(1 << 20);
			p.pos_y = rand_coord(1 << 20);
			// a camera looking down -z sees mostly negative z
			if (lean_back && $urandom_range(0, 3) != 0)
				p.pos_z = -$signed($urandom_range(0, 1 << 21));
			else
				p.pos_z = rand_coord(1 << 21);
			p.window_width = ($urandom_range(0, 6) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 2048));
			p.window_height = ($urandom_range(0, 6) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 2048));
			return p;
		end
	endfunction

	// wait for every outstanding request, then for the pipeline to settle
	task automatic drain_pipe();
		begin
			in_ch.valid <= 1'b0;
			while (pending_screens.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic load_matrix(input logic [REG_W-1:0] m [NUM_REGS]);
		begin
			drain_pipe();
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_we <= 1'b1;
				cfg_idx <= IDX_W'(i);
				cfg_data <= m[i];
				mtx_pairs[i] = m[i];
				@(posedge clk);
			end
			cfg_we <= 1'b0;
		end
	endtask

	// a gap of 0 keeps valid high into the next request
	task automatic send_point(input point_t p, input bit typed, input screen_t hand);
		int gap;
		begin
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.pos_x <= p.pos_x;
			in_ch.pos_y <= p.pos_y;
			in_ch.pos_z <= p.pos_z;
			in_ch.window_width <= p.window_width;
			in_ch.window_height <= p.window_height;
			do @(posedge clk); while (!in_ch.ready);
			pending_screens.push_back(typed ? hand : project_point(p));
		end
	endtask

	task automatic add_row(input int sel, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [15:0] ww, input logic [15:0] wh,
			input bit typed);
		row_t r;
		begin
			r.mtx_sel = sel;
			r.pt.pos_x = x;
			r.pt.pos_y = y;
			r.pt.pos_z = z;
			r.pt.window_width = ww;
			r.pt.window_height = wh;
			r.typed = typed;
			// every hand-typed row is a rejected point or an all-zero screen
			r.res.visible = (sel == 1) && (z == 32'd6554);
			r.res.screen_x = '0;
			r.res.screen_y = '0;
			r.res.saturated = 1'b0;
			directed_rows.push_back(r);
		end
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		screen_t want;
		int draw;
		if (out_ch.valid && out_ch.ready) begin
			idle_cycles <= 0;
			results_seen++;
			if (out_ch.visible) visible_seen++;
			if (out_ch.saturated) saturated_seen++;
			if (pending_screens.size() == 0) begin
				$display("%0t: unexpected result vis=%0b x=%h y=%h sat=%0b", $time,
					out_ch.visible, out_ch.screen_x, out_ch.screen_y, out_ch.saturated);
				errors++;
			end else begin
				want = pending_screens.pop_front();
				if (out_ch.visible !== want.visible) begin
					$display("%0t: visible expected %0b actual %0b", $time,
						want.visible, out_ch.visible);
					errors++;
				end
				if (out_ch.screen_x !== want.screen_x) begin
					$display("%0t: screen_x expected %h actual %h", $time,
						want.screen_x, out_ch.screen_x);
					errors++;
				end
				if (out_ch.screen_y !== want.screen_y) begin
					$display("%0t: screen_y expected %h actual %h", $time,
						want.screen_y, out_ch.screen_y);
					errors++;
				end
				if (out_ch.saturated !== want.saturated) begin
					$display("%0t: saturated expected %0b actual %0b", $time,
						want.saturated, out_ch.saturated);
					errors++;
				end
			end
			// draw a new stall for the next result
			draw = calm ? 0 : $urandom_range(0, 7);
			stall_left <= (draw > 0) ? draw - 1 : 0;
			out_ch.ready <= (draw == 0);
		end else if (in_ch.valid && in_ch.ready) begin
			idle_cycles <= 0;
			out_ch.ready <= (stall_left == 0);
			if (stall_left > 0) stall_left <= stall_left - 1;
		end else begin
			idle_cycles <= idle_cycles + 1;
			out_ch.ready <= (stall_left == 0);
			if (stall_left > 0) stall_left <= stall_left - 1;
		end
	end

	// watchdog: too long with no request moving on either side
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		logic [REG_W-1:0] m [NUM_REGS];
		logic [REG_W-1:0] pass_thru [NUM_REGS];
		int cur_sel;
		point_t p;
		screen_t none;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.window_width = '0;
		in_ch.window_height = '0;
		out_ch.ready = 1'b0;
		none = '{default: '0};
		for (int i = 0; i < NUM_REGS; i++) mtx_pairs[i] = '0;

		// x and y pass through, w taken from z
		pass_thru = '{default: '0};
		pass_thru[0] = 64'h00000000_00010000;
		pass_thru[2] = 64'h00010000_00000000;
		pass_thru[5] = 64'h00010000_00000000;

		// after reset the matrix is zero, so every point is rejected
		add_row(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 1);
		add_row(0, 32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 16'h0000, 1);
		add_row(0, 32'h00000000, 32'hFFFFFFFF, 32'h00010000, 16'h0001, 16'h8000, 1);
		// w just below and exactly at the threshold, then negative w
		add_row(1, 32'h00010000, 32'h00010000, 32'd6553, 16'd640, 16'd480, 1);
		add_row(1, 32'h00000000, 32'h00000000, 32'd6554, 16'd0, 16'd0, 1);
		add_row(1, 32'h00010000, 32'h00010000, 32'hFFFF0000, 16'd640, 16'd480, 1);
		add_row(1, 32'h00010000, 32'h00010000, 32'h80000000, 16'd640, 16'd480, 1);
		// ordinary points, negative ndc, rounding of odd window sizes
		add_row(1, 32'h00008000, 32'hFFFF8000, 32'h00010000, 16'd640, 16'd480, 0);
		add_row(1, 32'hFFFFC000, 32'h00004000, 32'h00020000, 16'd641, 16'd481, 0);
		add_row(1, 32'h00012345, 32'hFFF54321, 32'h00030000, 16'd1920, 16'd1080, 0);
		// huge quotients of both signs, still below the hold limit
		add_row(1, 32'h7FFFFFFF, 32'h80000000, 32'd6554, 16'd640, 16'd480, 0);
		add_row(1, 32'h80000000, 32'h7FFFFFFF, 32'd6554, 16'd2, 16'd3, 0);
		// half height of one zeroes the ndc_y term even for a huge quotient
		add_row(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd6554, 16'd3, 16'd2, 0);
		// largest windows, at and past the edge of the screen range
		add_row(1, 32'h00010000, 32'h00010000, 32'h00010000, 16'hFFFF, 16'hFFFF, 0);
		add_row(1, 32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 16'hFFFF, 16'hFFFE, 0);
		add_row(1, 32'h00000000, 32'h00000000, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 0);
		add_row(1, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF, 16'h5555, 16'hAAAA, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		cur_sel = 0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].mtx_sel != cur_sel) begin
				load_matrix(pass_thru);
				cur_sel = directed_rows[i].mtx_sel;
			end
			send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].res);
		end

		// random part, one matrix setting per phase
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: m = '{default: '0};
				1, 4: begin
					// perspective-like: w = -z plus a little
					for (int i = 0; i < NUM_REGS; i++)
						m[i] = {32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
							32'($signed($urandom_range(0, 1 << 18)) - (1 << 17))};
					m[5][63:32] = 32'hFFFF0000;
					m[6] = {32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
						32'($signed($urandom_range(0, 1 << 21)) - (1 << 20))};
					m[7] = {32'($urandom_range(0, 1 << 16)),
						32'($signed($urandom_range(0, 1 << 21)) - (1 << 20))};
				end
				2: m = '{default: 64'hFFFFFFFF_FFFFFFFF};
				3: m = '{default: 64'h80000000_7FFFFFFF};
				default: for (int i = 0; i < NUM_REGS; i++) m[i] = {$urandom, $urandom};
			endcase
			load_matrix(m);
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// stretches with no idling at all on either side
				if (n % 48 == 0) calm = ($urandom_range(0, 3) == 0);
				// hold off once until the pipeline is empty
				if (ph == 1 && n == RAND_PER_PHASE / 2)
					drain_pipe();
				p = rand_point(ph == 1 || ph == 4);
				send_point(p, 0, none);
			end
		end
		calm = 0;

		drain_pipe();
		$display("covered %0d results: %0d visible, %0d saturated, over %0d matrix settings",
			results_seen, visible_seen, saturated_seen, 7);
		$display("zero, pass-through, perspective, all-ones and extreme matrices used");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
